// ===== design/dhd_pkg.sv =====
// Shared widths, constants and calendar helper functions for the date/hour
// difference block. No dependencies; used by every module of the block.
package dhd_pkg;

  // field widths of one timestamp
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;

  // absolute day count, absolute hour count and signed result width
  localparam int unsigned DCOUNT_W = 23;
  localparam int unsigned HCOUNT_W = 28;
  localparam int unsigned DIFF_W   = 28;

  // number of leap years below a 14-bit year fits in 12 bits
  localparam int unsigned LEAPS_W = 12;
  // days before a month, up to a whole year
  localparam int unsigned DBM_W   = 9;

  localparam int unsigned MAX_YEAR_DEF  = 9999;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned LEAP_MONTH    = 2;

  // divide by 100 through a reciprocal, exact for any 14-bit value
  localparam int unsigned RECIP100       = 5243;
  localparam int unsigned RECIP100_SHIFT = 19;
  localparam int unsigned PROD_W         = 27;
  localparam int unsigned Q100_W         = 8;

  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(v) * PROD_W'(RECIP100);
    return prod[PROD_W-1 -: Q100_W];
  endfunction

  // days of non-leap months before month m; month zero counts none,
  // months past december count the whole year
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

  // gregorian leap rule; a multiple of 100 is a multiple of 400 when its
  // hundreds count is a multiple of 4
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [Q100_W-1:0] q;
    logic [YEAR_W-1:0] r;
    q = div100(y);
    r = y - YEAR_W'(q) * YEAR_W'(100);
    return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
  endfunction

  // leap years among years 0 .. y-1, year 0 counted as leap
  function automatic logic [LEAPS_W-1:0] leaps_before(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic [LEAPS_W-1:0] p4;
    logic [Q100_W-1:0] p100;
    logic [Q100_W-1:0] p400;
    p    = y - YEAR_W'(1);
    p4   = p[YEAR_W-1:2];
    p100 = div100(p);
    p400 = div100(YEAR_W'(p4));
    if (y == '0) begin
      return '0;
    end
    return p4 - LEAPS_W'(p100) + LEAPS_W'(p400) + LEAPS_W'(1);
  endfunction

endpackage

// ===== design/dhd_day_count.sv =====
// Absolute day count of one gregorian date (year already clamped).
// Depends on dhd_pkg for widths and calendar helper functions.
module dhd_day_count (
  input  logic [dhd_pkg::YEAR_W-1:0]   year,
  input  logic [dhd_pkg::MONTH_W-1:0]  month,
  input  logic [dhd_pkg::DAY_W-1:0]    day,
  output logic [dhd_pkg::DCOUNT_W-1:0] days
);

  logic [dhd_pkg::DCOUNT_W-1:0] year_days;
  logic [dhd_pkg::LEAPS_W-1:0]  leaps;
  logic [dhd_pkg::DBM_W-1:0]    month_days;
  logic                         leap_day;

  // whole years, leap days of earlier years and whole months
  assign year_days  = dhd_pkg::DCOUNT_W'(year) * dhd_pkg::DCOUNT_W'(dhd_pkg::DAYS_PER_YEAR);
  assign leaps      = dhd_pkg::leaps_before(year);
  assign month_days = dhd_pkg::days_before_month(month);

  // extra day once february of a leap year is past
  assign leap_day = (month > dhd_pkg::MONTH_W'(dhd_pkg::LEAP_MONTH)) && dhd_pkg::is_leap(year);

  assign days = year_days + dhd_pkg::DCOUNT_W'(leaps) + dhd_pkg::DCOUNT_W'(month_days)
              + dhd_pkg::DCOUNT_W'(leap_day) + dhd_pkg::DCOUNT_W'(day);

endmodule

// ===== design/dhd_hour_diff.sv =====
// Hour counts of two dates and their saturated signed difference.
// Depends on dhd_pkg for widths and constants.
module dhd_hour_diff (
  input  logic [dhd_pkg::DCOUNT_W-1:0] a_days,
  input  logic [dhd_pkg::HOUR_W-1:0]   a_hour,
  input  logic [dhd_pkg::DCOUNT_W-1:0] b_days,
  input  logic [dhd_pkg::HOUR_W-1:0]   b_hour,
  output logic signed [dhd_pkg::DIFF_W-1:0] diff
);

  localparam int unsigned WIDE_W = dhd_pkg::HCOUNT_W + 1;

  logic [dhd_pkg::HCOUNT_W-1:0] a_hours;
  logic [dhd_pkg::HCOUNT_W-1:0] b_hours;
  logic [WIDE_W-1:0]            wide;

  // days times 24 plus hour
  assign a_hours = dhd_pkg::HCOUNT_W'(a_days) * dhd_pkg::HCOUNT_W'(dhd_pkg::HOURS_PER_DAY)
                 + dhd_pkg::HCOUNT_W'(a_hour);
  assign b_hours = dhd_pkg::HCOUNT_W'(b_days) * dhd_pkg::HCOUNT_W'(dhd_pkg::HOURS_PER_DAY)
                 + dhd_pkg::HCOUNT_W'(b_hour);

  // one extra bit holds the full signed difference
  assign wide = {1'b0, a_hours} - {1'b0, b_hours};

  // saturate when the top two bits disagree
  always_comb begin
    if (wide[WIDE_W-1] == wide[WIDE_W-2]) begin
      diff = wide[dhd_pkg::DIFF_W-1:0];
    end else if (wide[WIDE_W-1]) begin
      diff = {1'b1, {(dhd_pkg::DIFF_W-1){1'b0}}};
    end else begin
      diff = {1'b0, {(dhd_pkg::DIFF_W-1){1'b1}}};
    end
  end

endmodule

// ===== design/date_hour_difference_core.sv =====
// Takes two timestamps (year, month, day, hour) per beat and returns A minus B
// in hours with less, equal and less-or-equal flags. Years above MAX_YEAR are
// clamped first. The block is a three-register pipeline (input register, day
// count register, result register) that a beat passes through in that order;
// a new beat is taken every cycle unless in_stall is high; stalls hold the
// pipeline and any empty stage is refilled while the output waits. Depends on
// dhd_pkg, dhd_day_count and dhd_hour_diff.
module date_hour_difference_core #(
  parameter int unsigned MAX_YEAR = dhd_pkg::MAX_YEAR_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [dhd_pkg::YEAR_W-1:0]  a_year,
  input  logic [dhd_pkg::MONTH_W-1:0] a_month,
  input  logic [dhd_pkg::DAY_W-1:0]   a_day,
  input  logic [dhd_pkg::HOUR_W-1:0]  a_hour,
  input  logic [dhd_pkg::YEAR_W-1:0]  b_year,
  input  logic [dhd_pkg::MONTH_W-1:0] b_month,
  input  logic [dhd_pkg::DAY_W-1:0]   b_day,
  input  logic [dhd_pkg::HOUR_W-1:0]  b_hour,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [dhd_pkg::DIFF_W-1:0] hours_between,
  output logic is_less,
  output logic is_equal,
  output logic is_less_or_equal
);

  localparam int unsigned LIM_W = 17;
  localparam logic [LIM_W-1:0] YEAR_LIM = LIM_W'(MAX_YEAR);

  // stage control
  logic v1, v2;
  logic ready1, ready2, ready3;

  // stage 1: clamped input beat
  logic [dhd_pkg::YEAR_W-1:0]  s1_a_year, s1_b_year;
  logic [dhd_pkg::MONTH_W-1:0] s1_a_month, s1_b_month;
  logic [dhd_pkg::DAY_W-1:0]   s1_a_day, s1_b_day;
  logic [dhd_pkg::HOUR_W-1:0]  s1_a_hour, s1_b_hour;
  logic [dhd_pkg::YEAR_W-1:0]  a_year_clamp, b_year_clamp;

  // stage 2: day counts and ordering
  logic [dhd_pkg::DCOUNT_W-1:0] s2_a_days, s2_b_days;
  logic [dhd_pkg::HOUR_W-1:0]   s2_a_hour, s2_b_hour;
  logic                         s2_lt, s2_eq;
  logic [dhd_pkg::DCOUNT_W-1:0] a_days_next, b_days_next;
  logic                         lt_next, eq_next;

  logic signed [dhd_pkg::DIFF_W-1:0] diff_next;

  // backpressure chain: a stage loads when empty or when it drains
  assign ready3   = !out_valid || !out_stall;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // year clamp against the configured maximum
  assign a_year_clamp = ({{(LIM_W-dhd_pkg::YEAR_W){1'b0}}, a_year} > YEAR_LIM)
                      ? YEAR_LIM[dhd_pkg::YEAR_W-1:0] : a_year;
  assign b_year_clamp = ({{(LIM_W-dhd_pkg::YEAR_W){1'b0}}, b_year} > YEAR_LIM)
                      ? YEAR_LIM[dhd_pkg::YEAR_W-1:0] : b_year;

  // day counts of both dates
  dhd_day_count u_a_days (
    .year  (s1_a_year),
    .month (s1_a_month),
    .day   (s1_a_day),
    .days  (a_days_next)
  );

  dhd_day_count u_b_days (
    .year  (s1_b_year),
    .month (s1_b_month),
    .day   (s1_b_day),
    .days  (b_days_next)
  );

  // lexicographic order by year, month, day, hour
  always_comb begin
    if (s1_a_year != s1_b_year) begin
      lt_next = s1_a_year < s1_b_year;
    end else if (s1_a_month != s1_b_month) begin
      lt_next = s1_a_month < s1_b_month;
    end else if (s1_a_day != s1_b_day) begin
      lt_next = s1_a_day < s1_b_day;
    end else begin
      lt_next = s1_a_hour < s1_b_hour;
    end
    eq_next = (s1_a_year == s1_b_year) && (s1_a_month == s1_b_month)
           && (s1_a_day == s1_b_day) && (s1_a_hour == s1_b_hour);
  end

  // hour difference from the registered day counts
  dhd_hour_diff u_diff (
    .a_days (s2_a_days),
    .a_hour (s2_a_hour),
    .b_days (s2_b_days),
    .b_hour (s2_b_hour),
    .diff   (diff_next)
  );

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        out_valid <= v2;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1_a_year  <= a_year_clamp;
      s1_a_month <= a_month;
      s1_a_day   <= a_day;
      s1_a_hour  <= a_hour;
      s1_b_year  <= b_year_clamp;
      s1_b_month <= b_month;
      s1_b_day   <= b_day;
      s1_b_hour  <= b_hour;
    end
  end

  // day count register
  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      s2_a_days <= a_days_next;
      s2_b_days <= b_days_next;
      s2_a_hour <= s1_a_hour;
      s2_b_hour <= s1_b_hour;
      s2_lt     <= lt_next;
      s2_eq     <= eq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      hours_between    <= diff_next;
      is_less          <= s2_lt;
      is_equal         <= s2_eq;
      is_less_or_equal <= s2_lt || s2_eq;
    end
  end

  // less and equal never hold together
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(is_less && is_equal))
    else $error("less and equal flags both set");

  // equal timestamps give a zero difference
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && is_equal) |-> (hours_between == '0))
    else $error("equal timestamps with nonzero hour difference");

  // a full middle stage blocked by the output keeps its beat
  assert property (@(posedge clk) disable iff (rst) (v2 && !ready3) |=> v2)
    else $error("beat lost in day count stage");

  // an accepted beat is in the input register next cycle
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> v1)
    else $error("accepted beat not captured");

endmodule

// ===== verif/tb_date_hour_difference_core.sv =====
// Testbench for date_hour_difference_core: drives timestamp pairs, predicts
// the hour difference and ordering flags, and checks every result beat.
// Depends on dhd_pkg and date_hour_difference_core.
`timescale 1ns / 1ps

module tb_date_hour_difference_core;

  localparam int unsigned YEAR_W  = dhd_pkg::YEAR_W;
  localparam int unsigned MONTH_W = dhd_pkg::MONTH_W;
  localparam int unsigned DAY_W   = dhd_pkg::DAY_W;
  localparam int unsigned HOUR_W  = dhd_pkg::HOUR_W;
  localparam int unsigned DIFF_W  = dhd_pkg::DIFF_W;

  localparam int unsigned MAX_YEAR   = dhd_pkg::MAX_YEAR_DEF;
  localparam longint      HOURS_TOP  = (longint'(1) << (DIFF_W - 1)) - 1;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          HOLD_LEN   = 300;
  localparam int          TAIL_CYCLES = 10;

  // days before each month code; zero counts none, past december counts all
  localparam int MONTH_START [16] = '{0, 0, 31, 59, 90, 120, 151, 181,
                                      212, 243, 273, 304, 334, 365, 365, 365};
  localparam int MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
  } stamp_t;

  typedef struct {
    logic signed [DIFF_W-1:0] hours;
    logic lt;
    logic eq;
    logic le;
  } gap_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [YEAR_W-1:0]  a_year = '0;
  logic [MONTH_W-1:0] a_month = '0;
  logic [DAY_W-1:0]   a_day = '0;
  logic [HOUR_W-1:0]  a_hour = '0;
  logic [YEAR_W-1:0]  b_year = '0;
  logic [MONTH_W-1:0] b_month = '0;
  logic [DAY_W-1:0]   b_day = '0;
  logic [HOUR_W-1:0]  b_hour = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DIFF_W-1:0] hours_between;
  logic is_less;
  logic is_equal;
  logic is_less_or_equal;

  gap_t expected_gaps [$];
  gap_t want;
  int   errors = 0;
  bit   calm = 1'b0;
  int   hold_len = 0;
  int   hold_left = 0;
  int   rx_wait = 0;
  int   idle_cycles = 0;

  date_hour_difference_core #(
    .MAX_YEAR(MAX_YEAR)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .a_year(a_year),
    .a_month(a_month),
    .a_day(a_day),
    .a_hour(a_hour),
    .b_year(b_year),
    .b_month(b_month),
    .b_day(b_day),
    .b_hour(b_hour),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hours_between(hours_between),
    .is_less(is_less),
    .is_equal(is_equal),
    .is_less_or_equal(is_less_or_equal)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // gregorian leap rule, year zero included
  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // absolute hour count of a timestamp whose year is already clamped
  function automatic longint stamp_hours(stamp_t s);
    longint y;
    longint p;
    longint days;
    y = s.year;
    days = 365 * y + MONTH_START[s.month] + s.day;
    if (y != 0) begin
      p = y - 1;
      days += p / 4 - p / 100 + p / 400 + 1;
    end
    if (s.month > 2 && leap_year(y)) begin
      days += 1;
    end
    return days * 24 + s.hour;
  endfunction

  // difference and ordering flags after year clamping
  function automatic gap_t predict_gap(stamp_t a, stamp_t b);
    gap_t g;
    stamp_t ca;
    stamp_t cb;
    longint diff;
    ca = a;
    cb = b;
    if (ca.year > MAX_YEAR) ca.year = YEAR_W'(MAX_YEAR);
    if (cb.year > MAX_YEAR) cb.year = YEAR_W'(MAX_YEAR);
    diff = stamp_hours(ca) - stamp_hours(cb);
    if (diff > HOURS_TOP) diff = HOURS_TOP;
    if (diff < -HOURS_TOP - 1) diff = -HOURS_TOP - 1;
    g.hours = diff[DIFF_W-1:0];
    // packed field order gives year, month, day, hour precedence
    g.lt = ca < cb;
    g.eq = ca == cb;
    g.le = g.lt | g.eq;
    return g;
  endfunction

  function automatic stamp_t ts(int y, int m, int d, int h);
    stamp_t s;
    s.year  = YEAR_W'(y);
    s.month = MONTH_W'(m);
    s.day   = DAY_W'(d);
    s.hour  = HOUR_W'(h);
    return s;
  endfunction

  // a valid calendar timestamp
  function automatic stamp_t calendar_stamp();
    int y;
    int m;
    int last;
    y = $urandom_range(0, MAX_YEAR);
    m = $urandom_range(1, 12);
    last = MONTH_LEN[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
    return ts(y, m, $urandom_range(1, last), $urandom_range(0, 23));
  endfunction

  // every field over its full port width
  function automatic stamp_t raw_stamp();
    bit [31:0] r;
    r = $urandom();
    return r[$bits(stamp_t)-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, exp_val, $time);
    errors++;
  endtask

  // offer one beat after a random gap and hold it until accepted
  task automatic send_pair(stamp_t a, stamp_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    a_year  <= a.year;
    a_month <= a.month;
    a_day   <= a.day;
    a_hour  <= a.hour;
    b_year  <= b.year;
    b_month <= b.month;
    b_day   <= b.day;
    b_hour  <= b.hour;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_gaps.size() != 0) @(posedge clk);
  endtask

  // result check and input capture, one place for both handshakes
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_gaps.size() == 0) begin
        report_mismatch("beat with nothing expected, hours_between", hours_between, 0);
      end else begin
        want = expected_gaps.pop_front();
        if (hours_between !== want.hours)
          report_mismatch("hours_between", hours_between, want.hours);
        if (is_less !== want.lt)
          report_mismatch("is_less", is_less, want.lt);
        if (is_equal !== want.eq)
          report_mismatch("is_equal", is_equal, want.eq);
        if (is_less_or_equal !== want.le)
          report_mismatch("is_less_or_equal", is_less_or_equal, want.le);
      end
    end
    if (!rst && in_valid && !in_stall) begin
      expected_gaps.push_back(predict_gap({a_year, a_month, a_day, a_hour},
                                          {b_year, b_month, b_day, b_hour}));
    end
  end

  // receiver: random wait per result, plus a long hold on request
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (out_valid && !out_stall) begin
      rx_wait = calm ? 0 : $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // field extremes, clamping, month codes, leap rules and flag precedence
  task automatic test_directed();
    send_pair(ts(0, 1, 1, 0), ts(0, 1, 1, 0));
    send_pair(ts(0, 0, 0, 0), ts(0, 0, 0, 0));
    send_pair(ts(9999, 12, 31, 23), ts(0, 1, 1, 0));
    send_pair(ts(0, 1, 1, 0), ts(9999, 12, 31, 23));
    send_pair(ts(16383, 15, 31, 31), ts(0, 0, 0, 0));
    send_pair(ts(0, 0, 0, 0), ts(16383, 15, 31, 31));
    send_pair(ts(16383, 6, 15, 12), ts(9999, 6, 15, 12));
    send_pair(ts(10000, 1, 1, 0), ts(12345, 1, 1, 1));
    send_pair(ts(2000, 3, 1, 0), ts(2000, 2, 29, 0));
    send_pair(ts(1900, 3, 1, 0), ts(1900, 2, 28, 0));
    send_pair(ts(2024, 3, 1, 0), ts(2023, 3, 1, 0));
    send_pair(ts(0, 3, 1, 0), ts(0, 2, 28, 0));
    send_pair(ts(1, 1, 1, 0), ts(0, 12, 31, 23));
    send_pair(ts(2024, 0, 5, 5), ts(2024, 1, 5, 5));
    send_pair(ts(2024, 13, 1, 0), ts(2025, 1, 1, 0));
    send_pair(ts(2023, 15, 0, 0), ts(2023, 12, 31, 0));
    send_pair(ts(2023, 5, 0, 31), ts(2023, 4, 30, 24));
    send_pair(ts(2023, 5, 31, 0), ts(2023, 6, 1, 0));
    send_pair(ts(500, 7, 4, 10), ts(500, 7, 4, 11));
    send_pair(ts(500, 7, 5, 0), ts(500, 7, 4, 23));
    send_pair(ts(500, 8, 1, 0), ts(500, 7, 31, 23));
    send_pair(ts(400, 2, 29, 0), ts(100, 2, 28, 0));
    send_pair(ts(8191, 10, 21, 21), ts(5461, 5, 10, 10));
    wait_for_drain();
  endtask

  // valid calendar dates drawn at random
  task automatic test_calendar_random(int count);
    repeat (count) send_pair(calendar_stamp(), calendar_stamp());
    wait_for_drain();
  endtask

  // any bit pattern on every field
  task automatic test_raw_random(int count);
    repeat (count) send_pair(raw_stamp(), raw_stamp());
    wait_for_drain();
  endtask

  // pairs that differ in at most one field, to work the flag precedence
  task automatic test_near_pairs(int count);
    stamp_t a;
    stamp_t b;
    for (int i = 0; i < count; i++) begin
      calm = (i < count / 2);
      a = ($urandom_range(0, 7) == 0) ? raw_stamp() : calendar_stamp();
      b = a;
      case ($urandom_range(0, 5))
        0: b = a;
        1: b.hour = HOUR_W'($urandom_range(0, 23));
        2: b.day = DAY_W'($urandom_range(1, 28));
        3: b.month = MONTH_W'($urandom_range(1, 12));
        4: b.year = ($urandom_range(0, 1) == 0) ? a.year + 1'b1 : a.year - 1'b1;
        default: begin
          a.year = YEAR_W'($urandom_range(MAX_YEAR, 16383));
          b.year = YEAR_W'($urandom_range(MAX_YEAR, 16383));
        end
      endcase
      send_pair(a, b);
    end
    calm = 1'b0;
    wait_for_drain();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure(int count);
    calm = 1'b1;
    hold_len = HOLD_LEN;
    repeat (count) send_pair(raw_stamp(), calendar_stamp());
    calm = 1'b0;
    wait_for_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_calendar_random(900);
    test_raw_random(450);
    test_near_pairs(440);
    test_backpressure(60);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
